@@ rtl/rtcu_pkg.sv @@
package rtcu_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int YEAR_W      = 15;
    localparam int DAYS_W      = 25;
    localparam int TOD_W       = 20;
    localparam int OUT_W       = 41;

    localparam logic [CFG_INDEX_W-1:0] REG_BCD_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TWELVE_HOUR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_CENTURY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_YEAR  = 2'd3;

    localparam logic [CFG_DATA_W-1:0] PIVOT_RESET   = 14'd2020;
    localparam logic [7:0]            PIVOT_Q_RESET = 8'd20;

    localparam logic [27:0] RECIP_100  = 28'd5243;
    localparam int          SHIFT_100  = 19;
    localparam logic [15:0] RECIP_12   = 16'd171;
    localparam int          SHIFT_12   = 11;

    localparam logic signed [DAYS_W-1:0] EPOCH_DAYS_PLUS_ONE = 25'sd719529;
    localparam logic signed [OUT_W-1:0]  SECS_PER_DAY        = 41'sd86400;

    function automatic logic [7:0] bcd_dec(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'b0, b[7:4]};
        return 8'((tens << 3) + (tens << 1) + {4'b0, b[3:0]});
    endfunction

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

@@ rtl/rtc_fields_to_unix_seconds_unit.sv @@
// Converts one snapshot of raw real-time-clock bytes into signed seconds since
// 1970-01-01 00:00:00 in the proleptic Gregorian calendar.
// Input channel: in_valid with in_stall; a word is taken at a clock edge where
// in_valid is high and in_stall is low. The seven raw bytes travel as one word.
// Output channel: out_valid with out_stall; unix_seconds holds steady while the
// receiver stalls.
// The configuration port writes one register per edge with cfg_we high; write
// it only while no word is in flight.
// An accepted input word moves in order through the six register stages s1-s6.
// Throughput is one word per cycle while the output is not stalled; each stage
// holds a valid bit, so bubbles close up; a stall backs up one stage at a time.
// in_stall rises only when every stage holds a word and the output is stalled.
// Reset empties the pipeline and restores the registers to binary mode,
// 24-hour time, no century byte and a pivot year of 2020.
module rtc_fields_to_unix_seconds_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rtcu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rtcu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       raw_second,
    input  logic [7:0]                       raw_minute,
    input  logic [7:0]                       raw_hour,
    input  logic [7:0]                       raw_day,
    input  logic [7:0]                       raw_month,
    input  logic [7:0]                       raw_year,
    input  logic [7:0]                       raw_century,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [rtcu_pkg::OUT_W-1:0] unix_seconds
);
    import rtcu_pkg::*;

    logic                  bcd_mode_reg;
    logic                  twelve_hour_reg;
    logic                  has_century_reg;
    logic [CFG_DATA_W-1:0] pivot_year_reg;
    logic [7:0]            pivot_q_reg;
    logic [27:0]           pivot_prod;

    logic en1, en2, en3, en4, en5, en6;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;

    logic [7:0]        s1_sec_reg, s1_min_reg, s1_hr_reg, s1_day_reg, s1_m1_reg;
    logic [YEAR_W-1:0] s1_year_reg;
    logic [7:0]        s1_sec_next, s1_min_next, s1_hr_next, s1_day_next, s1_m1_next;
    logic [YEAR_W-1:0] s1_year_next;

    logic [YEAR_W-1:0] s2_year_reg;
    logic [12:0]       s2_q4_reg;
    logic [8:0]        s2_q100_reg, s2_d100_reg;
    logic [6:0]        s2_q400_reg;
    logic [3:0]        s2_midx_reg;
    logic [7:0]        s2_day_reg;
    logic [TOD_W-1:0]  s2_tod_reg;
    logic [12:0]       s2_q4_next;
    logic [8:0]        s2_q100_next, s2_d100_next;
    logic [6:0]        s2_q400_next;
    logic [3:0]        s2_midx_next;
    logic [TOD_W-1:0]  s2_tod_next;

    logic [23:0]      s3_base_reg, s3_base_next;
    logic [8:0]       s3_mstart_reg, s3_mstart_next;
    logic [7:0]       s3_day_reg;
    logic [TOD_W-1:0] s3_tod_reg;

    logic signed [DAYS_W-1:0] s4_days_reg, s4_days_next;
    logic [TOD_W-1:0]         s4_tod_reg;

    logic signed [OUT_W-1:0] s5_prod_reg, s5_prod_next;
    logic [TOD_W-1:0]        s5_tod_reg;

    logic signed [OUT_W-1:0] s6_unix_reg, s6_unix_next;

    assign pivot_prod = 28'(cfg_data) * RECIP_100;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_mode_reg    <= 1'b0;
            twelve_hour_reg <= 1'b0;
            has_century_reg <= 1'b0;
            pivot_year_reg  <= PIVOT_RESET;
            pivot_q_reg     <= PIVOT_Q_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BCD_MODE:    bcd_mode_reg    <= cfg_data[0];
                REG_TWELVE_HOUR: twelve_hour_reg <= cfg_data[0];
                REG_HAS_CENTURY: has_century_reg <= cfg_data[0];
                REG_PIVOT_YEAR:
                begin
                    pivot_year_reg <= cfg_data;
                    pivot_q_reg    <= 8'(pivot_prod >> SHIFT_100);
                end
            endcase
        end
    end

    assign en6      = !s6_valid_reg || !out_stall;
    assign en5      = !s5_valid_reg || en6;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
        end
    end

    // Decode the bytes, fold the hour to 24-hour form and build the full year.
    always_comb
    begin
        logic [7:0]        hr_low_dec;
        logic [7:0]        hr_sel;
        logic [7:0]        h12;
        logic [7:0]        yr_sel;
        logic [7:0]        cent_sel;
        logic [7:0]        mon_sel;
        logic [CFG_DATA_W-1:0] pivot_cent;
        logic [6:0]        pivot_mod;
        logic [YEAR_W-1:0] year_cent;
        logic [YEAR_W-1:0] year_win;

        hr_low_dec  = bcd_dec({1'b0, raw_hour[6:0]});
        s1_sec_next = bcd_mode_reg ? bcd_dec(raw_second) : raw_second;
        s1_min_next = bcd_mode_reg ? bcd_dec(raw_minute) : raw_minute;
        s1_day_next = bcd_mode_reg ? bcd_dec(raw_day) : raw_day;
        mon_sel     = bcd_mode_reg ? bcd_dec(raw_month) : raw_month;
        yr_sel      = bcd_mode_reg ? bcd_dec(raw_year) : raw_year;
        cent_sel    = bcd_mode_reg ? bcd_dec(raw_century) : raw_century;
        hr_sel      = bcd_mode_reg ? {raw_hour[7], hr_low_dec[6:0]} : raw_hour;

        h12 = (hr_sel[6:0] == 7'd12) ? 8'd0 : {1'b0, hr_sel[6:0]};
        if (hr_sel[7])
        begin
            h12 = h12 + 8'd12;
        end
        s1_hr_next = twelve_hour_reg ? h12 : hr_sel;

        pivot_cent = 14'(16'(pivot_q_reg) * 16'd100);
        pivot_mod  = 7'(pivot_year_reg - pivot_cent);
        year_cent  = 15'(cent_sel) * 15'd100 + 15'(yr_sel);
        year_win   = 15'(yr_sel) + ((yr_sel < {1'b0, pivot_mod}) ? 15'd100 : 15'd0)
                   + 15'(pivot_cent);
        s1_year_next = has_century_reg ? year_cent : year_win;
        s1_m1_next   = mon_sel - 8'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sec_reg  <= s1_sec_next;
            s1_min_reg  <= s1_min_next;
            s1_hr_reg   <= s1_hr_next;
            s1_day_reg  <= s1_day_next;
            s1_m1_reg   <= s1_m1_next;
            s1_year_reg <= s1_year_next;
        end
    end

    // Leap-day counts by reciprocal multiplication, month index and time of day.
    always_comb
    begin
        logic [27:0] p100;
        logic [27:0] pd100;
        logic [27:0] p400;
        logic [12:0] t400;
        logic [15:0] mprod;
        logic [4:0]  mq;

        s2_q4_next   = 13'((s1_year_reg + 15'd3) >> 2);
        p100         = 28'(s1_year_reg + 15'd99) * RECIP_100;
        s2_q100_next = 9'(p100 >> SHIFT_100);
        pd100        = 28'(s1_year_reg) * RECIP_100;
        s2_d100_next = 9'(pd100 >> SHIFT_100);
        t400         = 13'((s1_year_reg + 15'd399) >> 2);
        p400         = 28'(t400) * RECIP_100;
        s2_q400_next = 7'(p400 >> SHIFT_100);

        mprod        = 16'(s1_m1_reg) * RECIP_12;
        mq           = 5'(mprod >> SHIFT_12);
        s2_midx_next = 4'(s1_m1_reg - {mq, 3'b0} - {1'b0, mq, 2'b0});

        s2_tod_next = 20'(s1_hr_reg) * 20'd3600 + 20'(s1_min_reg) * 20'd60
                    + 20'(s1_sec_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_year_reg <= s1_year_reg;
            s2_q4_reg   <= s2_q4_next;
            s2_q100_reg <= s2_q100_next;
            s2_d100_reg <= s2_d100_next;
            s2_q400_reg <= s2_q400_next;
            s2_midx_reg <= s2_midx_next;
            s2_day_reg  <= s1_day_reg;
            s2_tod_reg  <= s2_tod_next;
        end
    end

    // The year is a multiple of 100 exactly when both quotients by 100 agree.
    always_comb
    begin
        logic leap;

        leap = (s2_year_reg[1:0] == 2'd0)
            && ((s2_q100_reg != s2_d100_reg) || (s2_d100_reg[1:0] == 2'd0));
        s3_mstart_next = month_start(leap, s2_midx_reg);
        s3_base_next   = 24'(s2_year_reg) * 24'd365 + 24'(s2_q4_reg)
                       + 24'(s2_q400_reg) - 24'(s2_q100_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_base_reg   <= s3_base_next;
            s3_mstart_reg <= s3_mstart_next;
            s3_day_reg    <= s2_day_reg;
            s3_tod_reg    <= s2_tod_reg;
        end
    end

    assign s4_days_next = $signed({1'b0, s3_base_reg}) + $signed({16'b0, s3_mstart_reg})
                        + $signed({17'b0, s3_day_reg}) - EPOCH_DAYS_PLUS_ONE;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_days_reg <= s4_days_next;
            s4_tod_reg  <= s3_tod_reg;
        end
    end

    always_comb
    begin
        logic signed [OUT_W-1:0] days_wide;

        days_wide    = OUT_W'(s4_days_reg);
        s5_prod_next = days_wide * SECS_PER_DAY;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_prod_reg <= s5_prod_next;
            s5_tod_reg  <= s4_tod_reg;
        end
    end

    assign s6_unix_next = s5_prod_reg + $signed({21'b0, s5_tod_reg});

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_unix_reg <= s6_unix_next;
        end
    end

    assign out_valid    = s6_valid_reg;
    assign unix_seconds = s6_unix_reg;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import rtcu_pkg::*;

    localparam int    PIPE_LATENCY  = 6;
    localparam int    CYCLE_LIMIT   = 300000;
    localparam longint DAY_SECONDS  = 86400;
    localparam int    EPOCH_YEAR_NR = 1970;
    localparam int    DAYS_BEFORE_MONTH [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
    } snapshot_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic [7:0]             raw_second  = '0;
    logic [7:0]             raw_minute  = '0;
    logic [7:0]             raw_hour    = '0;
    logic [7:0]             raw_day     = '0;
    logic [7:0]             raw_month   = '0;
    logic [7:0]             raw_year    = '0;
    logic [7:0]             raw_century = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic signed [OUT_W-1:0] unix_seconds;

    bit cfg_bcd     = 1'b0;
    bit cfg_twelve  = 1'b0;
    bit cfg_century = 1'b0;
    int cfg_pivot   = 2020;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    logic [OUT_W-1:0] expected_seconds_q [$];
    logic [OUT_W-1:0] oldest_seconds;

    rtc_fields_to_unix_seconds_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .raw_second  (raw_second),
        .raw_minute  (raw_minute),
        .raw_hour    (raw_hour),
        .raw_day     (raw_day),
        .raw_month   (raw_month),
        .raw_year    (raw_year),
        .raw_century (raw_century),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .unix_seconds(unix_seconds)
    );

    always #5 clk = ~clk;

    function automatic longint decode_bcd(input logic [7:0] b);
        return longint'(b[7:4]) * 10 + longint'(b[3:0]);
    endfunction

    function automatic logic [7:0] encode_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic longint days_to_jan1(input longint y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic logic [OUT_W-1:0] predict_unix_seconds(input snapshot_t s);
        longint sec_v;
        longint minute_v;
        longint hour_v;
        longint day_v;
        longint month_v;
        longint year_v;
        longint century_v;
        longint h;
        longint month_idx;
        longint days;
        longint total;
        bit     leap;
        sec_v     = s.second;
        minute_v  = s.minute;
        hour_v    = s.hour;
        day_v     = s.day;
        month_v   = s.month;
        year_v    = s.year;
        century_v = s.century;
        if (cfg_bcd)
        begin
            sec_v     = decode_bcd(s.second);
            minute_v  = decode_bcd(s.minute);
            hour_v    = decode_bcd({1'b0, s.hour[6:0]}) + (s.hour[7] ? 128 : 0);
            day_v     = decode_bcd(s.day);
            month_v   = decode_bcd(s.month);
            year_v    = decode_bcd(s.year);
            century_v = decode_bcd(s.century);
        end
        if (cfg_twelve)
        begin
            h = hour_v & 127;
            if (h == 12)
            begin
                h = 0;
            end
            if ((hour_v & 128) != 0)
            begin
                h += 12;
            end
            hour_v = h;
        end
        if (cfg_century)
        begin
            year_v += century_v * 100;
        end
        else
        begin
            if (year_v < cfg_pivot % 100)
            begin
                year_v += 100;
            end
            year_v += cfg_pivot - cfg_pivot % 100;
        end
        month_idx = ((month_v + 255) & 255) % 12;
        leap = (year_v % 400 == 0) || ((year_v % 100 != 0) && (year_v % 4 == 0));
        days = days_to_jan1(year_v) - days_to_jan1(EPOCH_YEAR_NR)
             + DAYS_BEFORE_MONTH[month_idx] + ((leap && month_idx >= 2) ? 1 : 0)
             + day_v - 1;
        total = days * DAY_SECONDS + hour_v * 3600 + minute_v * 60 + sec_v;
        return total[OUT_W-1:0];
    endfunction

    function automatic snapshot_t make_snapshot(input logic [7:0] sec, input logic [7:0] minute,
                                                input logic [7:0] hour, input logic [7:0] day,
                                                input logic [7:0] month, input logic [7:0] year,
                                                input logic [7:0] century);
        snapshot_t s;
        s = '{sec, minute, hour, day, month, year, century};
        return s;
    endfunction

    function automatic snapshot_t random_snapshot();
        snapshot_t s;
        int        h;
        int        pm;
        if ($urandom_range(99) < 25)
        begin
            s = 56'({$urandom, $urandom});
            return s;
        end
        if (cfg_twelve)
        begin
            h  = $urandom_range(1, 12);
            pm = $urandom_range(1);
        end
        else
        begin
            h  = $urandom_range(23);
            pm = 0;
        end
        if (cfg_bcd)
        begin
            s.second  = encode_bcd($urandom_range(59));
            s.minute  = encode_bcd($urandom_range(59));
            s.hour    = encode_bcd(h) | 8'(pm << 7);
            s.day     = encode_bcd($urandom_range(1, 31));
            s.month   = encode_bcd($urandom_range(1, 12));
            s.year    = encode_bcd($urandom_range(99));
            s.century = encode_bcd($urandom_range(19, 21));
        end
        else
        begin
            s.second  = 8'($urandom_range(59));
            s.minute  = 8'($urandom_range(59));
            s.hour    = 8'(h) | 8'(pm << 7);
            s.day     = 8'($urandom_range(1, 31));
            s.month   = 8'($urandom_range(1, 12));
            s.year    = 8'($urandom_range(99));
            s.century = 8'($urandom_range(19, 21));
        end
        if ($urandom_range(99) < 10)
        begin
            case ($urandom_range(6))
                0: s.second  = 8'($urandom);
                1: s.minute  = 8'($urandom);
                2: s.hour    = 8'($urandom);
                3: s.day     = 8'($urandom);
                4: s.month   = 8'($urandom);
                5: s.year    = 8'($urandom);
                default: s.century = 8'($urandom);
            endcase
        end
        return s;
    endfunction

    task automatic send_snapshot(input snapshot_t s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        raw_second  <= s.second;
        raw_minute  <= s.minute;
        raw_hour    <= s.hour;
        raw_day     <= s.day;
        raw_month   <= s.month;
        raw_year    <= s.year;
        raw_century <= s.century;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
            begin
                break;
            end
        end
        @(posedge clk);
        expected_seconds_q.push_back(predict_unix_seconds(s));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_seconds_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic configure(input bit bcd, input bit twelve, input bit century,
                             input int pivot);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BCD_MODE;
        cfg_data  <= CFG_DATA_W'(bcd);
        @(posedge clk);
        cfg_index <= REG_TWELVE_HOUR;
        cfg_data  <= CFG_DATA_W'(twelve);
        @(posedge clk);
        cfg_index <= REG_HAS_CENTURY;
        cfg_data  <= CFG_DATA_W'(century);
        @(posedge clk);
        cfg_index <= REG_PIVOT_YEAR;
        cfg_data  <= CFG_DATA_W'(pivot);
        @(posedge clk);
        cfg_we      <= 1'b0;
        cfg_bcd     = bcd;
        cfg_twelve  = twelve;
        cfg_century = century;
        cfg_pivot   = pivot;
    endtask

    task automatic configure_random();
        int pivot;
        case ($urandom_range(3))
            0: pivot = 0;
            1: pivot = 9999;
            2: pivot = 2020;
            default: pivot = $urandom_range(9999);
        endcase
        configure(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  pivot);
    endtask

    task automatic test_reset_defaults();
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (5) send_snapshot(random_snapshot());
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(1'b0, 1'b0, 1'b0, 2020);
        send_snapshot(make_snapshot(0, 0, 0, 0, 0, 0, 0));
        send_snapshot(make_snapshot(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_snapshot(make_snapshot(59, 59, 23, 29, 2, 24, 0));
        send_snapshot(make_snapshot(0, 0, 0, 0, 0, 19, 0));
        send_snapshot(make_snapshot(30, 30, 12, 1, 1, 20, 0));
        send_snapshot(make_snapshot(0, 0, 8'h80, 15, 6, 150, 0));
        send_snapshot(make_snapshot(0, 0, 0, 1, 13, 70, 0));
        configure(1'b1, 1'b1, 1'b1, 0);
        send_snapshot(make_snapshot(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h70, 8'h19));
        send_snapshot(make_snapshot(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h70, 8'h19));
        send_snapshot(make_snapshot(8'h59, 8'h59, 8'h91, 8'h31, 8'h12, 8'h99, 8'h20));
        send_snapshot(make_snapshot(8'hfa, 8'haf, 8'h7f, 8'hff, 8'hfc, 8'hfe, 8'hff));
        send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h19));
        send_snapshot(make_snapshot(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00, 8'h20));
        send_snapshot(make_snapshot(0, 0, 0, 0, 0, 0, 0));
        configure(1'b0, 1'b1, 1'b0, 9999);
        send_snapshot(make_snapshot(0, 0, 12, 1, 1, 98, 0));
        send_snapshot(make_snapshot(0, 0, 8'h8c, 1, 1, 99, 0));
        send_snapshot(make_snapshot(0, 0, 8'h7f, 1, 1, 0, 0));
        send_snapshot(make_snapshot(0, 0, 8'hff, 1, 1, 0, 0));
        configure(1'b1, 1'b0, 1'b0, 0);
        send_snapshot(make_snapshot(8'h99, 8'h99, 8'hff, 8'h99, 8'h99, 8'h99, 8'h00));
        configure(1'b0, 1'b0, 1'b1, 2020);
        send_snapshot(make_snapshot(255, 255, 255, 255, 255, 255, 255));
        send_snapshot(make_snapshot(0, 0, 0, 1, 1, 0, 0));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_rate);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        repeat (3)
        begin
            configure_random();
            repeat (70) send_snapshot(random_snapshot());
        end
    endtask

    task automatic test_sender_pause();
        send_idle_pct = 22;
        stall_pct     = 22;
        configure_random();
        repeat (30) send_snapshot(random_snapshot());
        in_valid <= 1'b0;
        while (expected_seconds_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) send_snapshot(random_snapshot());
    endtask

    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_seconds_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %0d",
                         $time, unix_seconds);
                error_count++;
            end
            else
            begin
                oldest_seconds = expected_seconds_q.pop_front();
                if (unix_seconds !== oldest_seconds)
                begin
                    $display("%0t: unix_seconds mismatch, expected %0d, actual %0d",
                             $time, $signed(oldest_seconds), unix_seconds);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_traffic(0, 0);
        test_random_traffic(61, 0);
        test_random_traffic(0, 61);
        test_random_traffic(22, 22);
        test_sender_pause();
        wait_idle();
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
